/* hw/rtl/f2i_pkg.sv */
// Package for the saturating float-to-integer converter.
// Holds mode codes, field widths and the stage-to-stage struct. No dependencies.
package f2i_pkg;

    typedef enum logic [1:0] {
        MODE_S2I = 2'd0,
        MODE_S2L = 2'd1,
        MODE_D2I = 2'd2,
        MODE_D2L = 2'd3
    } mode_t;

    localparam int EXP_W  = 11;
    localparam int MANT_W = 53;
    localparam int SH_W   = 6;

    // Decoded operand, unified to double-width fields.
    typedef struct packed {
        logic              neg;
        logic              is_zero;   // NaN, zero, subnormal, below one
        logic              is_sat;    // infinity or at/beyond range
        logic              wide;      // 64-bit target
        logic [MANT_W-1:0] mant;      // implicit one included, left aligned at bit 52
        logic [SH_W-1:0]   rshift;    // right shift applied to mant
    } dec_t;

endpackage

/* hw/rtl/f2i_decode.sv */
// Decode stage of the converter: classifies the operand and computes the shift.
// Depends on f2i_pkg.
module f2i_decode (
    input  logic [1:0]   mode,
    input  logic [63:0]  operand_bits,
    output f2i_pkg::dec_t dec
);
    import f2i_pkg::*;

    logic              dbl;
    logic [EXP_W-1:0]  efield;
    logic [51:0]       frac;
    logic              emax_hit;
    logic signed [12:0] e;
    logic [6:0]        tlim;

    always_comb
    begin
        dbl  = (mode == MODE_D2I) || (mode == MODE_D2L);
        dec.wide = (mode == MODE_S2L) || (mode == MODE_D2L);
        if (dbl)
        begin
            dec.neg  = operand_bits[63];
            efield   = operand_bits[62:52];
            frac     = operand_bits[51:0];
            emax_hit = (operand_bits[62:52] == 11'h7ff);
            e        = $signed({2'b00, operand_bits[62:52]}) - 13'sd1023;
        end
        else
        begin
            dec.neg  = operand_bits[31];
            efield   = {3'b000, operand_bits[30:23]};
            frac     = {operand_bits[22:0], 29'd0};
            emax_hit = (operand_bits[30:23] == 8'hff);
            e        = $signed({5'b00000, operand_bits[30:23]}) - 13'sd127;
        end
        tlim = dec.wide ? 7'd63 : 7'd31;
        dec.mant = {1'b1, frac};
        dec.is_zero = 1'b0;
        dec.is_sat  = 1'b0;
        dec.rshift  = '0;
        if (emax_hit)
        begin
            dec.is_zero = (frac != 52'd0);
            dec.is_sat  = (frac == 52'd0);
        end
        else if (efield == '0 || e < 13'sd0)
            dec.is_zero = 1'b1;
        else if (e >= $signed({6'd0, tlim}))
            dec.is_sat = 1'b1;
        else
            // e in 0..62; value = mant >> (52 - e), left shift when e > 52
            dec.rshift = (e <= 13'sd52) ? SH_W'(13'sd52 - e) : '0;
        // e > 52 only in 64-bit targets: mant is cleared as a marker; the top level supplies the left-shifted value
        if (!emax_hit && efield != '0 && e > 13'sd52 && e < $signed({6'd0, tlim}))
            dec.mant = MANT_W'(0);
    end
endmodule

/* hw/rtl/float_to_int_saturating_convert.sv */
// Saturating float-to-integer converter, single/double to int32/int64.
// start passes v1_reg, v2_reg, v3_reg to done. Throughput: one transaction per cycle.
// busy is always low; the result strobe cannot be stalled by the receiver.
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload is not reset.
// Depends on f2i_pkg and f2i_decode.
module float_to_int_saturating_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [63:0] operand_bits,
    output logic        done,
    output logic signed [63:0] result_value
);
    import f2i_pkg::*;

    dec_t        dec;
    logic [63:0] lmag;
    logic [5:0]  lsh;

    dec_t        s1_reg;
    logic [63:0] s1_big_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic [63:0] mag_reg, mag_next;
    logic        s2_neg_reg, s2_zero_reg, s2_sat_reg, s2_wide_reg;
    logic [63:0] res_reg, res_next;

    assign busy = 1'b0;

    f2i_decode u_dec (
        .mode         (mode),
        .operand_bits (operand_bits),
        .dec          (dec)
    );

    // Large exponents (above 52) need a left shift; precompute it here.
    always_comb
    begin
        lsh  = (mode[1]) ? 6'(operand_bits[62:52] - 11'd1075)
                         : 6'(operand_bits[30:23] - 8'd150);
        lmag = (mode[1]) ? ({11'd1, operand_bits[51:0]} << lsh)
                         : ({40'd1, operand_bits[22:0]} << lsh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg     <= dec;
        s1_big_reg <= lmag;
        mag_reg    <= mag_next;
        s2_neg_reg <= s1_reg.neg;
        s2_zero_reg <= s1_reg.is_zero;
        s2_sat_reg <= s1_reg.is_sat;
        s2_wide_reg <= s1_reg.wide;
        res_reg    <= res_next;
    end

    // Stage 2: alignment shift.
    always_comb
    begin
        if (s1_reg.mant == '0)
            mag_next = s1_big_reg;
        else
            mag_next = {11'd0, s1_reg.mant} >> s1_reg.rshift;
    end

    // Stage 3: sign, saturation and width.
    always_comb
    begin
        if (s2_zero_reg)
            res_next = 64'd0;
        else if (s2_sat_reg)
            res_next = s2_wide_reg ? (s2_neg_reg ? 64'h8000000000000000 : 64'h7fffffffffffffff)
                                   : (s2_neg_reg ? 64'hffffffff80000000 : 64'h000000007fffffff);
        else
            res_next = s2_neg_reg ? (64'd0 - mag_reg) : mag_reg;
    end

    assign done         = v3_reg;
    assign result_value = res_reg;

    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> ##1 v3_reg)
        else $error("valid lost in pipeline");
    a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && s2_zero_reg) |=> (result_value == 64'd0))
        else $error("zero class gave nonzero result");
    a_narrow_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !s2_wide_reg) |=>
        (result_value[63:31] == '0 || result_value[63:31] == '1))
        else $error("32-bit result not sign-extended");
endmodule
